### src/rtts_pkg.sv
// Shared constants, register indexes and fixed-point helpers for the rotor thrust/torque step.
package rtts_pkg;

    localparam int DATA_W     = 32;
    localparam int DT_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = 50;
    localparam int MAG_W      = 49;
    localparam int DIV_NUM_W  = 48;
    localparam int DIV_RADIX  = 2;
    localparam int DIV_STEPS  = DIV_NUM_W / DIV_RADIX;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [DT_W-1:0] LAG_RESET = 16'd1311;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRUST_COEFF = 3'd0,
        REG_DRAG_COEFF   = 3'd1,
        REG_ROTOR_INERTIA = 3'd2,
        REG_SPIN_NEGATIVE = 3'd3,
        REG_ARM_X        = 3'd4,
        REG_ARM_Y        = 3'd5,
        REG_LAG_TIME     = 3'd6
    } t_reg_idx;

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
        return x[DATA_W-1] ? (~x + 32'd1) : x;
    endfunction

    function automatic logic [DATA_W-1:0] sat_acc(input logic [ACC_W-1:0] v);
        if (v[ACC_W-1:DATA_W-1] == '0 || v[ACC_W-1:DATA_W-1] == '1) begin
            return v[DATA_W-1:0];
        end
        return v[ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    endfunction

    // Signed Q16.16 term from a magnitude product: drop 16 fraction bits, then sign.
    function automatic logic [ACC_W-1:0] prod_term(input logic [PROD_W-1:0] p, input logic neg);
        logic [ACC_W-1:0] m;
        m = {{(ACC_W - (PROD_W - 16)){1'b0}}, p[PROD_W-1:16]};
        return neg ? (~m + 1'b1) : m;
    endfunction

    function automatic logic [DATA_W-1:0] cap_neg(input logic [MAG_W-1:0] m);
        logic [DATA_W-1:0] c;
        c = (m > 49'h0_8000_0000) ? 32'h8000_0000 : m[DATA_W-1:0];
        return ~c + 32'd1;
    endfunction

    function automatic logic [DATA_W-1:0] cap_pos(input logic [MAG_W-1:0] m);
        return (m >= 49'h0_7fff_ffff) ? 32'h7fff_ffff : m[DATA_W-1:0];
    endfunction

endpackage

### src/rtts_if.sv
// Valid/ready channel interfaces for input items, results and register writes.
interface rtts_in_if import rtts_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] target_speed;
    logic signed [DATA_W-1:0] roll_rate;
    logic signed [DATA_W-1:0] pitch_rate;
    logic        [DT_W-1:0]   step_time;

    modport source (output valid, target_speed, roll_rate, pitch_rate, step_time, input ready);
    modport sink   (input valid, target_speed, roll_rate, pitch_rate, step_time, output ready);
endinterface

interface rtts_out_if import rtts_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] force_z;
    logic signed [DATA_W-1:0] torque_x;
    logic signed [DATA_W-1:0] torque_y;
    logic signed [DATA_W-1:0] torque_z;

    modport source (output valid, force_z, torque_x, torque_y, torque_z, input ready);
    modport sink   (input valid, force_z, torque_x, torque_y, torque_z, output ready);
endinterface

interface rtts_cfg_if import rtts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/rtts_div.sv
// Iterative radix-4 restoring divider: 48-bit numerator by 16-bit divisor.
module rtts_div import rtts_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DT_W-1:0]      i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quo
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DT_W-1:0]      r_rem;
    logic [DT_W-1:0]      r_den;
    logic [DIV_NUM_W-1:0] n_num;
    logic [DT_W-1:0]      n_rem;

    always_comb begin
        logic [DT_W:0] t;
        n_rem = r_rem;
        n_num = r_num;
        for (int k = 0; k < DIV_RADIX; k++) begin
            t = {n_rem, n_num[DIV_NUM_W-1]};
            n_num = {n_num[DIV_NUM_W-2:0], 1'b0};
            if (t >= {1'b0, r_den}) begin
                t = t - {1'b0, r_den};
                n_num[0] = 1'b1;
            end
            n_rem = t[DT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

### src/rotor_thrust_torque_step.sv
// Top level: one-rotor thrust, reaction and gyroscopic torque with first-order-lag speed update.
// One item is taken at a time. After the input transfer the item runs through the steps of
// the single registered 32x32 multiplier (11 products: speed square, gyroscopic moment,
// split coefficient products, arm and gyro torque products, lag step numerator; the last
// step hands the numerator to the divider), then 24 radix-4 steps of the divide by lag_time.
// The input is ready again once the result is in the output register, so no new item is
// taken before the last one is finished; a stalled result holds the next item's finish,
// not its start. The result reflects the motor speed held before the item; the speed is
// updated as the result is registered.
module rotor_thrust_torque_step import rtts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rtts_in_if.sink    i_in,
    rtts_out_if.source o_out,
    rtts_cfg_if.sink   i_cfg
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    localparam logic [3:0] SP_SQ    = 4'd0;
    localparam logic [3:0] SP_GYRO  = 4'd1;
    localparam logic [3:0] SP_KF_HI = 4'd2;
    localparam logic [3:0] SP_KF_LO = 4'd3;
    localparam logic [3:0] SP_KM_HI = 4'd4;
    localparam logic [3:0] SP_KM_LO = 4'd5;
    localparam logic [3:0] SP_AY    = 4'd6;
    localparam logic [3:0] SP_QH    = 4'd7;
    localparam logic [3:0] SP_PH    = 4'd8;
    localparam logic [3:0] SP_AX    = 4'd9;
    localparam logic [3:0] SP_LAG   = 4'd10;
    localparam logic [3:0] SP_LAST  = 4'd11;

    t_state r_state;
    logic [3:0] r_step;

    logic [DATA_W-1:0] r_kf;
    logic [DATA_W-1:0] r_km;
    logic [DATA_W-1:0] r_jr;
    logic              r_sneg;
    logic [DATA_W-1:0] r_arm_x;
    logic [DATA_W-1:0] r_arm_y;
    logic [DT_W-1:0]   r_lag;
    logic [DATA_W-1:0] r_w;

    logic [DATA_W-1:0] r_wm;
    logic [DATA_W-1:0] r_dmag;
    logic              r_dneg;
    logic [DATA_W-1:0] r_p;
    logic [DATA_W-1:0] r_q;
    logic [DT_W-1:0]   r_dt;

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_sq;
    logic [PROD_W-1:0] r_acc;
    logic [DATA_W-1:0] r_hm;
    logic [DATA_W-1:0] r_fz;
    logic [DATA_W-1:0] r_fzmag;
    logic [DATA_W-1:0] r_tz;
    logic [ACC_W-1:0]  r_accx;
    logic [ACC_W-1:0]  r_accy;
    logic [DIV_NUM_W-1:0] r_quo;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_fz;
    logic [DATA_W-1:0] r_out_tx;
    logic [DATA_W-1:0] r_out_ty;
    logic [DATA_W-1:0] r_out_tz;

    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [DATA_W:0]   diff;
    logic [DATA_W:0]   diff_abs;
    logic [PROD_W:0]   coeff_sum;
    logic [MAG_W-1:0]  coeff_mag;
    logic [DATA_W-1:0] fz_cap;
    logic              hneg;
    logic [ACC_W-1:0]  w_next;
    logic [ACC_W-1:0]  delta;
    logic [DT_W-1:0]   tau;
    logic              in_xfer;
    logic              out_load;
    logic              div_start;
    logic              div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_load    = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);
    assign div_start   = (r_state == ST_MUL) && (r_step == SP_LAST);
    assign tau         = (r_lag == '0) ? DT_W'(1) : r_lag;
    assign hneg        = r_sneg ^ r_w[DATA_W-1];

    assign diff     = {i_in.target_speed[DATA_W-1], i_in.target_speed} - {r_w[DATA_W-1], r_w};
    assign diff_abs = diff[DATA_W] ? ((DATA_W+1)'(0) - diff) : diff;

    assign coeff_sum = {1'b0, r_acc} + {{(DATA_W+1){1'b0}}, r_prod[PROD_W-1:DATA_W]};
    assign coeff_mag = coeff_sum[MAG_W+15:16];
    assign fz_cap    = cap_neg(coeff_mag);

    assign delta  = r_dneg ? (~{2'b00, r_quo} + 1'b1) : {2'b00, r_quo};
    assign w_next = {{(ACC_W-DATA_W){r_w[DATA_W-1]}}, r_w} + delta;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            SP_SQ: begin
                mul_a = r_wm;
                mul_b = r_wm;
            end
            SP_GYRO: begin
                mul_a = r_jr;
                mul_b = r_wm;
            end
            SP_KF_HI: begin
                mul_a = r_sq[PROD_W-1:DATA_W];
                mul_b = r_kf;
            end
            SP_KF_LO: begin
                mul_a = r_sq[DATA_W-1:0];
                mul_b = r_kf;
            end
            SP_KM_HI: begin
                mul_a = r_sq[PROD_W-1:DATA_W];
                mul_b = r_km;
            end
            SP_KM_LO: begin
                mul_a = r_sq[DATA_W-1:0];
                mul_b = r_km;
            end
            SP_AY: begin
                mul_a = mag32(r_arm_y);
                mul_b = r_fzmag;
            end
            SP_QH: begin
                mul_a = mag32(r_q);
                mul_b = r_hm;
            end
            SP_PH: begin
                mul_a = mag32(r_p);
                mul_b = r_hm;
            end
            SP_AX: begin
                mul_a = mag32(r_arm_x);
                mul_b = r_fzmag;
            end
            SP_LAG: begin
                mul_a = r_dmag;
                mul_b = {{(DATA_W-DT_W){1'b0}}, r_dt};
            end
            default: begin
            end
        endcase
    end

    rtts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod[DIV_NUM_W-1:0]),
        .i_den   (tau),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kf    <= '0;
            r_km    <= '0;
            r_jr    <= '0;
            r_sneg  <= 1'b0;
            r_arm_x <= '0;
            r_arm_y <= '0;
            r_lag   <= LAG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_THRUST_COEFF:  r_kf    <= i_cfg.data;
                REG_DRAG_COEFF:    r_km    <= i_cfg.data;
                REG_ROTOR_INERTIA: r_jr    <= i_cfg.data;
                REG_SPIN_NEGATIVE: r_sneg  <= i_cfg.data[0];
                REG_ARM_X:         r_arm_x <= i_cfg.data;
                REG_ARM_Y:         r_arm_y <= i_cfg.data;
                REG_LAG_TIME:      r_lag   <= i_cfg.data[DT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= SP_SQ;
            r_w         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_state <= ST_MUL;
                        r_step  <= SP_SQ;
                    end
                end
                ST_MUL: begin
                    if (r_step == SP_LAST) begin
                        r_state <= ST_DIV;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_w     <= sat_acc(w_next);
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {{DATA_W{1'b0}}, mul_a} * {{DATA_W{1'b0}}, mul_b};
        if (in_xfer) begin
            r_wm   <= mag32(r_w);
            r_dmag <= diff_abs[DATA_W-1:0];
            r_dneg <= diff[DATA_W];
            r_p    <= i_in.roll_rate;
            r_q    <= i_in.pitch_rate;
            r_dt   <= i_in.step_time;
        end
        if (r_state == ST_MUL) begin
            case (r_step)
                SP_GYRO:  r_sq <= r_prod;
                SP_KF_HI: r_hm <= r_prod[PROD_W-1:DATA_W];
                SP_KF_LO: r_acc <= r_prod;
                SP_KM_HI: begin
                    r_fz    <= fz_cap;
                    r_fzmag <= mag32(fz_cap);
                end
                SP_KM_LO: r_acc <= r_prod;
                SP_AY:    r_tz <= r_sneg ? cap_neg(coeff_mag) : cap_pos(coeff_mag);
                SP_QH:    r_accx <= prod_term(r_prod, r_arm_y[DATA_W-1] ^ (r_fzmag != '0));
                SP_PH:    r_accx <= r_accx - prod_term(r_prod, r_q[DATA_W-1] ^ hneg);
                SP_AX:    r_accy <= prod_term(r_prod, r_p[DATA_W-1] ^ hneg);
                SP_LAG:   r_accy <= r_accy - prod_term(r_prod,
                                                       r_arm_x[DATA_W-1] ^ (r_fzmag != '0));
                default: begin
                end
            endcase
        end
        if (r_state == ST_DIV && div_done) begin
            r_quo <= div_quo;
        end
        if (out_load) begin
            r_out_fz <= r_fz;
            r_out_tx <= sat_acc(r_accx);
            r_out_ty <= sat_acc(r_accy);
            r_out_tz <= r_tz;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.force_z  = r_out_fz;
    assign o_out.torque_x = r_out_tx;
    assign o_out.torque_y = r_out_ty;
    assign o_out.torque_z = r_out_tz;

    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == ST_MUL) && (r_step == SP_SQ))
        else $error("sequencer did not start after input transfer");

    a_div_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) && div_done |=> (r_state == ST_DONE))
        else $error("divide completion not followed by finish");

    a_speed_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_w) |-> $past(r_state == ST_DONE))
        else $error("motor speed changed outside the finish step");

endmodule

### tb/sv/rotor_thrust_torque_step_test.sv
`timescale 1ns / 1ps
// Self-checking bench for rotor_thrust_torque_step: directed and random items against a fixed-point predictor.
module rotor_thrust_torque_step_test;
    import rtts_pkg::*;

    localparam int QUIET_LIMIT     = 5000;
    localparam int PARK_CYCLES     = 600;
    localparam int DRAIN_CYCLES    = 60;
    localparam int LOUD_MISMATCHES = 10;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int RANDOM_PHASES   = 6;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam logic [DATA_W-1:0]    W_MAX     = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0]    W_MIN     = 32'h8000_0000;
    localparam longint               Q_MAX     = 64'sh7fff_ffff;
    localparam longint               Q_MIN     = -64'sh8000_0000;

    typedef struct packed {
        logic [DATA_W-1:0] target_speed;
        logic [DATA_W-1:0] roll_rate;
        logic [DATA_W-1:0] pitch_rate;
        logic [DT_W-1:0]   step_time;
    } rotor_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] force_z;
        logic [DATA_W-1:0] torque_x;
        logic [DATA_W-1:0] torque_y;
        logic [DATA_W-1:0] torque_z;
    } rotor_load_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    rtts_in_if  cmd_if ();
    rtts_out_if load_if ();
    rtts_cfg_if reg_if ();

    rotor_thrust_torque_step dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (load_if),
        .i_cfg   (reg_if)
    );

    always #2 i_clk = ~i_clk;

    rotor_cmd_t  cmd_pending[$];
    rotor_load_t load_expected[$];
    reg_write_t  reg_pending[$];

    int          src_idle_pct  = 38;
    int          sink_idle_pct = 57;
    bit          park_armed    = 1'b0;
    int          park_count    = 0;
    bit          cmd_sent      = 1'b0;
    int          quiet_cycles  = 0;
    int          mismatches    = 0;
    rotor_cmd_t  cmd_next;
    rotor_load_t load_got;
    rotor_load_t load_want;

    // predictor copy of the registers and the motor speed
    logic [31:0] thrust_k    = '0;
    logic [31:0] drag_k      = '0;
    logic [31:0] inertia_k   = '0;
    logic        spin_neg    = 1'b0;
    logic [31:0] mount_x     = '0;
    logic [31:0] mount_y     = '0;
    logic [15:0] lag_tau     = LAG_RESET;
    logic [31:0] rotor_speed = '0;

    function automatic bit [63:0] abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint with_sign(bit [63:0] m, bit neg);
        longint s;
        s = m;
        return neg ? -s : s;
    endfunction

    function automatic longint clamp_q(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // Q16.16 product on magnitudes, truncated toward zero
    function automatic longint qmul(longint a, longint b);
        bit [63:0] m;
        m = (abs64(a) * abs64(b)) >> 16;
        return with_sign(m, (a < 0) != (b < 0));
    endfunction

    // loads of the speed held before the item, then one lag step of the speed
    function automatic rotor_load_t rotor_response(rotor_cmd_t c);
        longint      w, tgt, p, q, fz, tz, h, diff;
        bit [63:0]   wm, sq, hm, dm, tau;
        bit [95:0]   lift, drag;
        rotor_load_t r;
        w    = $signed(rotor_speed);
        tgt  = $signed(c.target_speed);
        p    = $signed(c.roll_rate);
        q    = $signed(c.pitch_rate);
        wm   = abs64(w);
        sq   = wm * wm;
        lift = 96'(sq) * 96'(thrust_k);
        drag = 96'(sq) * 96'(drag_k);
        fz   = clamp_q(-longint'(lift[95:48]));
        tz   = clamp_q(with_sign(drag[95:48], spin_neg));
        hm   = (64'(inertia_k) * wm) >> 32;
        h    = with_sign(hm, spin_neg != (w < 0));
        r.force_z  = 32'(fz);
        r.torque_x = 32'(clamp_q(qmul($signed(mount_y), fz) - qmul(q, h)));
        r.torque_y = 32'(clamp_q(qmul(p, h) - qmul($signed(mount_x), fz)));
        r.torque_z = 32'(tz);
        diff = tgt - w;
        tau  = (lag_tau == '0) ? 64'd1 : 64'(lag_tau);
        dm   = (abs64(diff) * 64'(c.step_time)) / tau;
        rotor_speed = 32'(clamp_q(w + with_sign(dm, diff < 0)));
        return r;
    endfunction

    function automatic logic [31:0] pick_signed(int small_bits);
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return W_MAX;
            1: return W_MIN;
            2: return '0;
            3, 4, 5: return r;
            default: return $signed(r) >>> (32 - small_bits);
        endcase
    endfunction

    function automatic logic [31:0] pick_coeff();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return $urandom;
            default: return $urandom >> $urandom_range(8, 30);
        endcase
    endfunction

    function automatic void queue_cmd(logic [31:0] t, logic [31:0] p, logic [31:0] q,
                                      logic [15:0] dt);
        cmd_pending.push_back({t, p, q, dt});
    endfunction

    function automatic void queue_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        reg_pending.push_back({idx, data});
    endfunction

    task automatic wait_drained();
        while (cmd_pending.size() != 0 || cmd_if.valid || load_expected.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic program_regs();
        reg_write_t wr;
        @(negedge i_clk);
        while (reg_pending.size() != 0) begin
            wr = reg_pending.pop_front();
            reg_if.valid <= 1'b1;
            reg_if.index <= wr.index;
            reg_if.data  <= wr.data;
            do @(posedge i_clk); while (!(reg_if.valid && reg_if.ready));
            @(negedge i_clk);
        end
        reg_if.valid <= 1'b0;
    endtask

    // item driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_sent) begin
            if (cmd_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                cmd_next = cmd_pending.pop_front();
                cmd_if.valid        <= 1'b1;
                cmd_if.target_speed <= cmd_next.target_speed;
                cmd_if.roll_rate    <= cmd_next.roll_rate;
                cmd_if.pitch_rate   <= cmd_next.pitch_rate;
                cmd_if.step_time    <= cmd_next.step_time;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // result sink, with one long hold-off when armed
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            load_if.ready <= 1'b0;
        end else if (park_armed && park_count < PARK_CYCLES) begin
            park_count    <= park_count + 1;
            load_if.ready <= 1'b0;
        end else begin
            load_if.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // monitor, scoreboard and watchdog
    always @(posedge i_clk) begin
        cmd_sent <= cmd_if.valid && cmd_if.ready;
        if (i_rst_n) begin
            if (load_if.valid && load_if.ready) begin
                load_got = {load_if.force_z, load_if.torque_x, load_if.torque_y,
                            load_if.torque_z};
                if (load_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= LOUD_MISMATCHES)
                        $display("%0t: result transfer with none pending: %h", $time, load_got);
                end else begin
                    load_want = load_expected.pop_front();
                    if (load_got.force_z !== load_want.force_z
                            || load_got.torque_x !== load_want.torque_x
                            || load_got.torque_y !== load_want.torque_y
                            || load_got.torque_z !== load_want.torque_z) begin
                        mismatches++;
                        if (mismatches <= LOUD_MISMATCHES)
                            $display("%0t: exp fz %h tx %h ty %h tz %h, got fz %h tx %h ty %h tz %h",
                                     $time, load_want.force_z, load_want.torque_x,
                                     load_want.torque_y, load_want.torque_z, load_got.force_z,
                                     load_got.torque_x, load_got.torque_y, load_got.torque_z);
                    end
                end
            end
            if (cmd_if.valid && cmd_if.ready)
                load_expected.push_back(rotor_response({cmd_if.target_speed, cmd_if.roll_rate,
                                                        cmd_if.pitch_rate, cmd_if.step_time}));
            if (reg_if.valid && reg_if.ready) begin
                case (reg_if.index)
                    REG_THRUST_COEFF:  thrust_k  = reg_if.data;
                    REG_DRAG_COEFF:    drag_k    = reg_if.data;
                    REG_ROTOR_INERTIA: inertia_k = reg_if.data;
                    REG_SPIN_NEGATIVE: spin_neg  = reg_if.data[0];
                    REG_ARM_X:         mount_x   = reg_if.data;
                    REG_ARM_Y:         mount_y   = reg_if.data;
                    REG_LAG_TIME:      lag_tau   = reg_if.data[DT_W-1:0];
                    default: ;
                endcase
            end
            if ((cmd_if.valid && cmd_if.ready) || (load_if.valid && load_if.ready)
                    || (reg_if.valid && reg_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] lag_word;
        cmd_if.valid        = 1'b0;
        cmd_if.target_speed = '0;
        cmd_if.roll_rate    = '0;
        cmd_if.pitch_rate   = '0;
        cmd_if.step_time    = '0;
        load_if.ready       = 1'b0;
        reg_if.valid        = 1'b0;
        reg_if.index        = '0;
        reg_if.data         = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values, lag at its default
        queue_cmd(W_MAX, W_MIN, W_MAX, 16'hffff);
        queue_cmd(W_MIN, 32'h0001_0000, 32'hffff_0000, 16'd1311);
        queue_cmd('0, '0, '0, '0);
        wait_drained();

        // all coefficients full scale, reverse spin, shortest lag, dead index ignored
        queue_reg(REG_THRUST_COEFF, '1);
        queue_reg(REG_DRAG_COEFF, '1);
        queue_reg(REG_ROTOR_INERTIA, '1);
        queue_reg(REG_SPIN_NEGATIVE, 32'hffff_ffff);
        queue_reg(REG_ARM_X, W_MIN);
        queue_reg(REG_ARM_Y, W_MAX);
        queue_reg(REG_LAG_TIME, 32'h5a5a_0001);
        queue_reg(REG_SPARE, 32'h1234_5678);
        program_regs();
        queue_cmd(W_MAX, W_MAX, W_MIN, 16'hffff);
        queue_cmd('0, W_MIN, W_MIN, '0);
        queue_cmd(W_MIN, W_MAX, W_MAX, 16'hffff);
        queue_cmd('0, 32'hffff_ffff, 32'h0000_0001, 16'd1);
        queue_cmd(32'h0001_0000, '0, '0, 16'hffff);
        queue_cmd('0, '0, '0, 16'hffff);
        wait_drained();

        // zero thrust, forward spin, lag of zero taken as one
        queue_reg(REG_THRUST_COEFF, '0);
        queue_reg(REG_DRAG_COEFF, 32'h0000_a7c5);
        queue_reg(REG_ROTOR_INERTIA, 32'h0001_0000);
        queue_reg(REG_SPIN_NEGATIVE, 32'hffff_fffe);
        queue_reg(REG_ARM_X, 32'h0000_4000);
        queue_reg(REG_ARM_Y, 32'hffff_c000);
        queue_reg(REG_LAG_TIME, 32'h8001_0000);
        program_regs();
        queue_cmd(32'h03e8_0000, 32'h0002_0000, 32'hfffe_0000, 16'd0);
        queue_cmd(32'h03e8_0000, 32'h0002_0000, 32'hfffe_0000, 16'd1);
        queue_cmd(32'hfc18_0000, 32'h0002_0000, 32'hfffe_0000, 16'd655);
        queue_cmd('0, W_MAX, W_MIN, 16'hffff);
        queue_cmd(W_MAX, '0, '0, 16'd200);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            src_idle_pct  = (ph < 2) ? 38 : (ph < 4) ? 57 : 0;
            sink_idle_pct = (ph < 2) ? 57 : (ph < 4) ? 38 : 0;
            lag_word = $urandom;
            case ((ph == 0) ? 2 : $urandom_range(6))
                0: lag_word[15:0] = '0;
                1: lag_word[15:0] = 16'd1;
                2: lag_word[15:0] = 16'hffff;
                3: lag_word[15:0] = LAG_RESET;
                default: lag_word[15:0] = 16'($urandom_range(1, 65535));
            endcase
            queue_reg(REG_THRUST_COEFF, pick_coeff());
            queue_reg(REG_DRAG_COEFF, pick_coeff());
            queue_reg(REG_ROTOR_INERTIA, pick_coeff());
            queue_reg(REG_SPIN_NEGATIVE, $urandom);
            queue_reg(REG_ARM_X, pick_signed(18));
            queue_reg(REG_ARM_Y, pick_signed(18));
            queue_reg(REG_LAG_TIME, lag_word);
            program_regs();
            if (ph == 2)
                park_armed = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(5))
                    0: queue_cmd(pick_signed(28), pick_signed(22), pick_signed(22), '0);
                    1: queue_cmd(pick_signed(28), pick_signed(22), pick_signed(22), 16'hffff);
                    2: queue_cmd(pick_signed(28), pick_signed(22), pick_signed(22),
                                 16'($urandom));
                    default: queue_cmd(pick_signed(28), pick_signed(22), pick_signed(22),
                                       16'($urandom_range(1, 1400)));
                endcase
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        mismatches += load_expected.size();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
